/* hdl/ups_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port steering package
// Shared constants, codes and the structs passed between the parser, the
// decision logic and the top level.
// ----------------------------------------------------------------------------
package ups_pkg;

	localparam int QUEUES_DEFAULT = 16;
	localparam int MASK_MAX       = 16;

	localparam int BYTE_W  = 8;
	localparam int QUEUE_W = 4;
	localparam int PORT_W  = 16;
	localparam int OFF_W   = 7;
	localparam int LEN_W   = OFF_W + 1;

	localparam logic [15:0] ETH_VLAN  = 16'h8100;
	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [15:0] ETH_IPV6  = 16'h86DD;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	localparam logic [OFF_W-1:0] OFF_MAX      = 7'd127;
	localparam logic [OFF_W-1:0] OFF_TYPE_HI  = 7'd12;
	localparam logic [OFF_W-1:0] OFF_TYPE_LO  = 7'd13;
	localparam logic [OFF_W-1:0] OFF_INNER_HI = 7'd16;
	localparam logic [OFF_W-1:0] OFF_INNER_LO = 7'd17;
	localparam logic [OFF_W-1:0] OFF_L3_MIN   = 7'd20;
	localparam logic [OFF_W-1:0] L3_PLAIN     = 7'd14;
	localparam logic [OFF_W-1:0] L3_TAGGED    = 7'd18;
	localparam logic [OFF_W-1:0] IPV4_HDR     = 7'd20;
	localparam logic [OFF_W-1:0] IPV6_HDR     = 7'd40;
	localparam logic [OFF_W-1:0] IPV4_PROTO   = 7'd9;
	localparam logic [OFF_W-1:0] IPV6_NEXT    = 7'd6;
	localparam logic [OFF_W-1:0] UDP_DPORT_HI = 7'd2;
	localparam logic [OFF_W-1:0] UDP_DPORT_LO = 7'd3;
	localparam logic [LEN_W-1:0] UDP_HDR      = 8'd8;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PORT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_MASK = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_PASS     = 2'd0,
		VERDICT_REDIRECT = 2'd1,
		VERDICT_DROP     = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [15:0]       ether_kind;
		logic              has_vlan;
		logic [7:0]        l4_proto;
		logic [PORT_W-1:0] captured_port;
	} frame_state_t;

	// frame state as seen after the current byte has been captured
	typedef struct packed {
		logic [OFF_W-1:0] offset;
		frame_state_t     fields;
	} frame_view_t;

endpackage

/* hdl/ups_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one frame byte with its end mark and queue.
// ----------------------------------------------------------------------------
interface ups_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;
	logic [3:0] queue_index;

	modport source (output valid, frame_byte, last_byte, queue_index, input ready);
	modport sink   (input valid, frame_byte, last_byte, queue_index, output ready);
endinterface

/* hdl/ups_verdict_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict channel
// Valid/ready channel carrying one steering verdict per frame.
// ----------------------------------------------------------------------------
interface ups_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [3:0] target_queue;

	modport source (output valid, verdict, target_queue, input ready);
	modport sink   (input valid, verdict, target_queue, output ready);
endinterface

/* hdl/ups_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ups_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/udp_port_frame_steering_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UDP port frame steering
// Parses Ethernet/802.1Q/IPv4/IPv6 headers byte by byte and gives one
// pass, redirect or drop verdict per frame on its final byte.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  transfer when
//  in_ch     in   frame_byte, last_byte, queue_index       valid && ready
//  out_ch    out  verdict, target_queue                    valid && ready
//  cfg       in   index (0 match port, 1 queue mask), data valid && ready
//
//  One byte per cycle while no final byte waits on a stalled verdict; a
//  verdict is valid the cycle after its final byte leaves the input register.
//  The path runs through the input register and the verdict register; the
//  header parse between them is a handful of offset compares.
//  Reset clears all frame state, input valid and the verdict register to zero.
//  A stalled verdict holds the input register only when it too carries a
//  final byte; other bytes keep flowing. cfg is always ready.
// ----------------------------------------------------------------------------
module udp_port_frame_steering_top
	import ups_pkg::*;
#(
	parameter int QUEUES = QUEUES_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	ups_byte_if.sink      in_ch,
	ups_verdict_if.source out_ch,
	ups_cfg_if.sink       cfg
);

	localparam int MASK_W = (QUEUES < MASK_MAX) ? QUEUES : MASK_MAX;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;
	logic [QUEUE_W-1:0] queue_s1;
	logic               advance_s1;

	logic [PORT_W-1:0]  match_port_q;
	logic [MASK_W-1:0]  queue_mask_q;

	logic               out_valid_q;
	verdict_t           verdict_q;
	logic [QUEUE_W-1:0] target_queue_q;

	frame_view_t        view;
	verdict_t           verdict_d;
	logic [QUEUE_W-1:0] target_queue_d;

	// only a final byte needs room in the verdict register
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance_s1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1  <= in_ch.frame_byte;
			last_s1  <= in_ch.last_byte;
			queue_s1 <= in_ch.queue_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q <= '0;
			queue_mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MATCH_PORT: match_port_q <= cfg.data;
				REG_QUEUE_MASK: queue_mask_q <= cfg.data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	ups_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance_s1),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.view       (view)
	);

	ups_decide #(
		.QUEUES (QUEUES)
	) u_decide (
		.view         (view),
		.queue_index  (queue_s1),
		.match_port   (match_port_q),
		.queue_mask   (queue_mask_q),
		.verdict      (verdict_d),
		.target_queue (target_queue_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			verdict_q      <= VERDICT_PASS;
			target_queue_q <= '0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q    <= 1'b1;
			verdict_q      <= verdict_d;
			target_queue_q <= target_queue_d;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.verdict      = verdict_q;
	assign out_ch.target_queue = target_queue_q;

	a_queue_only_on_redirect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q != VERDICT_REDIRECT |-> target_queue_q == '0)
		else $error("target queue set on a verdict other than redirect");

	a_verdict_after_final_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance_s1 && last_s1))
		else $error("verdict raised without a final byte");

	a_final_byte_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && !out_ch.ready |=> valid_s1 && last_s1)
		else $error("final byte lost while the verdict register was full");

endmodule

/* hdl/ups_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame header parser
// Holds the per-frame offset and header fields, captures the current byte
// and presents the updated view to the decision logic.
// ----------------------------------------------------------------------------
module ups_parser
	import ups_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [BYTE_W-1:0] frame_byte,
	input  logic              last_byte,
	output frame_view_t       view
);

	logic [OFF_W-1:0] offset_q;
	frame_state_t     state_q;
	frame_state_t     state_d;
	logic             is_ipv4;
	logic             is_ipv6;
	logic [OFF_W-1:0] l3_start;
	logic [OFF_W-1:0] l4_start;

	assign is_ipv4  = (state_q.ether_kind == ETH_IPV4);
	assign is_ipv6  = (state_q.ether_kind == ETH_IPV6);
	assign l3_start = state_q.has_vlan ? L3_TAGGED : L3_PLAIN;
	assign l4_start = l3_start + (is_ipv4 ? IPV4_HDR : IPV6_HDR);

	always_comb begin
		state_d = state_q;
		if (offset_q == OFF_TYPE_HI) begin
			state_d.ether_kind[15:8] = frame_byte;
		end else if (offset_q == OFF_TYPE_LO) begin
			state_d.ether_kind[7:0] = frame_byte;
			state_d.has_vlan = ({state_q.ether_kind[15:8], frame_byte} == ETH_VLAN);
		end else if (state_q.has_vlan && offset_q == OFF_INNER_HI) begin
			state_d.ether_kind[15:8] = frame_byte;
		end else if (state_q.has_vlan && offset_q == OFF_INNER_LO) begin
			state_d.ether_kind[7:0] = frame_byte;
		end else if (offset_q >= OFF_L3_MIN && (is_ipv4 || is_ipv6)) begin
			if (is_ipv4 && offset_q == l3_start + IPV4_PROTO) begin
				state_d.l4_proto = frame_byte;
			end else if (is_ipv6 && offset_q == l3_start + IPV6_NEXT) begin
				state_d.l4_proto = frame_byte;
			end else if (offset_q == l4_start + UDP_DPORT_HI) begin
				state_d.captured_port[15:8] = frame_byte;
			end else if (offset_q == l4_start + UDP_DPORT_LO) begin
				state_d.captured_port[7:0] = frame_byte;
			end
		end
	end

	assign view.offset = offset_q;
	assign view.fields = state_d;

	// clear everything at the end of a frame, saturate the offset otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			state_q  <= '0;
		end else if (advance) begin
			if (last_byte) begin
				offset_q <= '0;
				state_q  <= '0;
			end else begin
				state_q <= state_d;
				if (offset_q < OFF_MAX) begin
					offset_q <= offset_q + 7'd1;
				end
			end
		end
	end

endmodule

/* hdl/ups_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering decision
// Works out pass, redirect or drop from the parsed view of the final byte.
// ----------------------------------------------------------------------------
module ups_decide
	import ups_pkg::*;
#(
	parameter int QUEUES = QUEUES_DEFAULT,
	localparam int MASK_W = (QUEUES < MASK_MAX) ? QUEUES : MASK_MAX
) (
	input  frame_view_t        view,
	input  logic [QUEUE_W-1:0] queue_index,
	input  logic [PORT_W-1:0]  match_port,
	input  logic [MASK_W-1:0]  queue_mask,
	output verdict_t           verdict,
	output logic [QUEUE_W-1:0] target_queue
);

	logic [MASK_MAX-1:0] enable_vec;
	logic [LEN_W-1:0]    frame_len;
	logic [LEN_W-1:0]    l4_start;
	logic                is_ipv4;
	logic                is_ip;

	// queues at or above the configured count read as disabled
	for (genvar i = 0; i < MASK_MAX; i++) begin : g_enable
		if (i < MASK_W) begin : g_on
			assign enable_vec[i] = queue_mask[i];
		end else begin : g_off
			assign enable_vec[i] = 1'b0;
		end
	end

	assign frame_len = {1'b0, view.offset} + 8'd1;
	assign is_ipv4   = (view.fields.ether_kind == ETH_IPV4);
	assign is_ip     = is_ipv4 || (view.fields.ether_kind == ETH_IPV6);
	assign l4_start  = {1'b0, view.fields.has_vlan ? L3_TAGGED : L3_PLAIN}
			+ {1'b0, is_ipv4 ? IPV4_HDR : IPV6_HDR};

	always_comb begin
		verdict = VERDICT_PASS;
		if (!enable_vec[queue_index]) begin
			verdict = VERDICT_PASS;
		end else if (frame_len < {1'b0, L3_PLAIN}) begin
			verdict = VERDICT_PASS;
		end else if (view.fields.has_vlan && frame_len < {1'b0, L3_TAGGED}) begin
			verdict = VERDICT_PASS;
		end else if (!is_ip || frame_len < l4_start) begin
			verdict = VERDICT_PASS;
		end else if (view.fields.l4_proto != PROTO_UDP) begin
			verdict = VERDICT_PASS;
		end else if (frame_len < l4_start + UDP_HDR) begin
			verdict = VERDICT_DROP;
		end else if (view.fields.captured_port == match_port) begin
			verdict = VERDICT_REDIRECT;
		end
	end

	assign target_queue = (verdict == VERDICT_REDIRECT) ? queue_index : '0;

endmodule
